// File: rtl/podc_pkg.sv
// ----------------------------------------------------------------------------
// podc_pkg: shared definitions for the position-offset decimal codec
// Character codes, the default position width and the command word that the
// sequencer sends to the binary-to-decimal unit.
// ----------------------------------------------------------------------------
package podc_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;

  localparam logic [7:0] TERM_CHAR = 8'h23;   // '#'
  localparam logic [7:0] ZERO_CHAR = 8'h30;   // '0'
  localparam logic [3:0] RADIX     = 4'd10;

  // Command word from the sequencer to the shared conversion unit.
  typedef struct packed {
    logic load;    // take a new binary value, clear the decimal digits
    logic conv;    // one double-dabble step: adjust the digits, shift one bit in
    logic shift;   // drop the top decimal digit
  } podc_cmd_t;

endpackage : podc_pkg

// File: rtl/podc_dabble.sv
// ----------------------------------------------------------------------------
// podc_dabble: iterative binary-to-decimal conversion unit
// Holds the binary value and its packed decimal digits. Each conversion step
// adds three to every digit of five or more and shifts one binary bit in.
// ----------------------------------------------------------------------------
module podc_dabble #(
  parameter int unsigned VALUE_BITS = 17,
  parameter int unsigned DIGITS     = 6
) (
  input  logic                  clk,
  input  podc_pkg::podc_cmd_t   cmd,
  input  logic [VALUE_BITS-1:0] load_value,
  output logic [3:0]            top_digit
);
  import podc_pkg::*;

  localparam int unsigned BCD_BITS = DIGITS * 4;

  logic [VALUE_BITS-1:0] bin_r;
  logic [BCD_BITS-1:0]   bcd_r;
  logic [BCD_BITS-1:0]   bcd_adj;

  // Every digit is adjusted on its own, so this loop is a row of lanes.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= load_value;
      bcd_r <= '0;
    end else if (cmd.conv) begin
      bin_r <= {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_r <= {bcd_adj[BCD_BITS-2:0], bin_r[VALUE_BITS-1]};
    end else if (cmd.shift) begin
      bcd_r <= {bcd_r[BCD_BITS-5:0], 4'd0};
    end
  end

  assign top_digit = bcd_r[BCD_BITS-1 -: 4];

endmodule : podc_dabble

// File: rtl/position_offset_decimal_codec_unit.sv
// ----------------------------------------------------------------------------
// position_offset_decimal_codec_unit: position-offset decimal byte codec
// Encode: each byte plus its 1-based position is sent as decimal ASCII digits,
// most significant first, then '#' marked as the last beat. Decode: digits are
// folded into an accumulator modulo 256, and '#' returns accumulator minus
// position modulo 256.
//
//   Channel | Signals                          | Beat carries
//   --------+----------------------------------+---------------------------------
//   in      | in_tvalid/in_tready              | tdata: byte; tuser: restart
//   out     | out_tvalid/out_tready            | tdata: byte; tlast: final beat
//   cfg     | cfg_valid/cfg_ready              | cfg_data: decode_mode
//
// An encoded byte is accepted, converted bit by bit in the shared
// double-dabble unit, then its leading zero digits are dropped until the
// leading digit is found; the lowest digit is always kept. Each digit is
// then sent, most significant first, followed by the '#'.
// A decimal digit in decode mode is absorbed in its accept cycle; a '#'
// moves to a result state that hands its result to the output register.
// Other bytes are ignored.
// Reset is synchronous and active low; it clears position, accumulator, the
// mode register and the output valid flag. A stalled output holds its beat and
// only the sequencer waits; the output register is released as it is taken.
// ----------------------------------------------------------------------------
module position_offset_decimal_codec_unit #(
  parameter int unsigned POSITION_BITS = podc_pkg::POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tuser,    // [0] restart
  // Result channel.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,
  // Configuration channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data     // [0] decode_mode
);
  import podc_pkg::*;

  // The encoded sum needs one bit more than the position. The digit count
  // is floor(bits * log10(2)) + 1, enough for any value of that width.
  localparam int unsigned VALUE_BITS = POSITION_BITS + 1;
  localparam int unsigned DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned CW         = $clog2(VALUE_BITS + 1);
  localparam int unsigned DW         = $clog2(DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT,
    ST_TERM,
    ST_DEC_OUT
  } state_t;

  state_t                   state_r;
  logic                     decode_mode_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [7:0]               acc_r;
  logic [CW-1:0]            bit_cnt_r;
  logic [DW-1:0]            dig_cnt_r;
  logic [7:0]               dec_byte_r;
  logic                     out_valid_r;
  logic [7:0]               out_byte_r;
  logic                     out_last_r;

  logic                     in_accept;
  logic                     out_free;
  logic                     out_load;
  logic [POSITION_BITS-1:0] pos_base;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic [7:0]               acc_base;
  logic [11:0]              acc_prod;
  logic [7:0]               acc_nxt;
  logic                     is_digit;
  logic                     is_term;
  logic [VALUE_BITS-1:0]    enc_value;
  logic [3:0]               top_digit;
  podc_cmd_t                cmd;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // The output register takes a new beat in any sending state once it is free.
  assign out_load  = out_free && ((state_r == ST_EMIT) || (state_r == ST_TERM)
                               || (state_r == ST_DEC_OUT));

  // A restart clears position and accumulator before the byte is used.
  assign pos_base  = in_tuser ? '0 : pos_r;
  assign acc_base  = in_tuser ? 8'd0 : acc_r;
  assign pos_nxt   = pos_base + POSITION_BITS'(1);
  assign enc_value = VALUE_BITS'(pos_nxt) + VALUE_BITS'(in_tdata);

  assign is_digit  = (in_tdata >= ZERO_CHAR) && (in_tdata <= ZERO_CHAR + 8'd9);
  assign is_term   = (in_tdata == TERM_CHAR);
  assign acc_prod  = 12'(acc_base) * 12'(RADIX);
  assign acc_nxt   = acc_prod[7:0] + (in_tdata - ZERO_CHAR);

  // Commands to the shared conversion unit.
  always_comb begin
    cmd       = '0;
    cmd.load  = in_accept && !decode_mode_r;
    cmd.conv  = (state_r == ST_CONV);
    cmd.shift = ((state_r == ST_SKIP) && (top_digit == 4'd0) && (dig_cnt_r != DW'(1)))
             || ((state_r == ST_EMIT) && out_free);
  end

  podc_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk        (clk),
    .cmd        (cmd),
    .load_value (enc_value),
    .top_digit  (top_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      decode_mode_r <= 1'b0;
      pos_r         <= '0;
      acc_r         <= 8'd0;
      out_valid_r   <= 1'b0;
      bit_cnt_r     <= '0;
      dig_cnt_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        decode_mode_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (!decode_mode_r) begin
              pos_r     <= pos_nxt;
              acc_r     <= acc_base;
              bit_cnt_r <= CW'(VALUE_BITS);
              state_r   <= ST_CONV;
            end else if (is_digit) begin
              pos_r <= pos_base;
              acc_r <= acc_nxt;
            end else if (is_term) begin
              pos_r      <= pos_nxt;
              acc_r      <= 8'd0;
              dec_byte_r <= acc_base - pos_nxt[7:0];
              state_r    <= ST_DEC_OUT;
            end else begin
              // Not a token character: only a restart leaves a trace.
              pos_r <= pos_base;
              acc_r <= acc_base;
            end
          end
        end

        ST_CONV: begin
          bit_cnt_r <= bit_cnt_r - CW'(1);
          if (bit_cnt_r == CW'(1)) begin
            dig_cnt_r <= DW'(DIGITS);
            state_r   <= ST_SKIP;
          end
        end

        ST_SKIP: begin
          // Leading zeros are dropped, but the lowest digit is always sent.
          if ((top_digit == 4'd0) && (dig_cnt_r != DW'(1))) begin
            dig_cnt_r <= dig_cnt_r - DW'(1);
          end else begin
            state_r <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_byte_r  <= ZERO_CHAR + 8'(top_digit);
            out_last_r  <= 1'b0;
            dig_cnt_r   <= dig_cnt_r - DW'(1);
            if (dig_cnt_r == DW'(1)) begin
              state_r <= ST_TERM;
            end
          end
        end

        ST_TERM: begin
          if (out_free) begin
            out_byte_r  <= TERM_CHAR;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end

        ST_DEC_OUT: begin
          if (out_free) begin
            out_byte_r  <= dec_byte_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule : position_offset_decimal_codec_unit

// File: rtl/podc_checker.sv
// ----------------------------------------------------------------------------
// podc_checker: port-level checks for the position-offset decimal codec
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module podc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_ready
);
  import podc_pkg::*;

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A beat that is not the last one of its item is always a decimal digit.
  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata >= ZERO_CHAR) && (out_tdata <= ZERO_CHAR + 8'd9))
    else $error("non-final beat is not a digit");

  // While a token is still being sent, no new byte is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken in the middle of a token");

  // Reset leaves no result beat behind.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

  // The mode register is always writable.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule : podc_checker

bind position_offset_decimal_codec_unit podc_checker u_podc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);

// File: bench/tb_position_offset_decimal_codec_unit.sv
// ----------------------------------------------------------------------------
// tb_position_offset_decimal_codec_unit: self-checking bench for the codec
// A queue-fed driver offers byte beats, a monitor checks every result beat
// against a cycle-free model of the codec, and both channels idle at random.
// Encode and decode phases alternate, with one long output stall; the sender
// waits for every owed result to come back before each mode write and at the end.
// ----------------------------------------------------------------------------
module tb_position_offset_decimal_codec_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import podc_pkg::*;

  // Margin for any work still in flight once the last result has been taken.
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct {
    logic [7:0]  data;
    logic        restart;
    int unsigned gap;
  } byte_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } codec_symbol_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic       in_tuser   = 1'b0;   // [0] restart
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic       cfg_data   = 1'b0;   // [0] decode_mode

  position_offset_decimal_codec_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Bytes waiting to be offered, and the symbols the codec still owes us.
  byte_item_t    byte_backlog [$];
  codec_symbol_t due_symbols  [$];

  // Shadow copy of the codec's state and its mode register.
  logic [POSITION_BITS_DEF-1:0] codec_pos  = '0;
  logic [7:0]                   digit_acc  = '0;
  logic                         decode_sel = 1'b0;

  // Handshake flags passed from the rising-edge monitor to the falling-edge
  // drivers; they are written and read at different edges, so never race.
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  bit cfg_taken = 1'b0;

  // Idling controls set per phase by the stimulus sequence.
  int unsigned gap_ceiling   = 7;
  int unsigned stall_ceiling = 7;
  int unsigned stall_left    = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  int unsigned items_taken  = 0;
  int unsigned symbols_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned enc_items    = 0;
  int unsigned dec_results  = 0;
  int unsigned fault_count  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous bound on the whole run: about ten times what it needs even when
  // every gap and every stall is drawn at its longest.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Works out the symbols one accepted byte beat causes, in the same order
  // the codec must send them, and updates the shadow state.
  task automatic forecast_symbols(input logic [7:0] b, input logic rs);
    logic [3:0]    digits [0:9];
    int unsigned   v;
    int unsigned   nd;
    codec_symbol_t s;
    if (rs) begin
      codec_pos = '0;
      digit_acc = '0;
    end
    if (!decode_sel) begin
      // Encode: the byte plus its position, most significant digit first.
      codec_pos = codec_pos + 1'b1;
      v = b + codec_pos;
      nd = 0;
      do begin
        digits[nd] = v % RADIX;
        nd++;
        v = v / RADIX;
      end while (v != 0);
      for (int k = nd; k > 0; k--) begin
        s.data = ZERO_CHAR + digits[k-1];
        s.last = 1'b0;
        due_symbols.push_back(s);
      end
      s.data = TERM_CHAR;
      s.last = 1'b1;
      due_symbols.push_back(s);
      enc_items++;
    end else if (b >= ZERO_CHAR && b <= ZERO_CHAR + 8'd9) begin
      // A digit only folds into the accumulator, modulo 256.
      digit_acc = digit_acc * RADIX + (b - ZERO_CHAR);
    end else if (b == TERM_CHAR) begin
      codec_pos = codec_pos + 1'b1;
      s.data = digit_acc - codec_pos[7:0];
      s.last = 1'b1;
      due_symbols.push_back(s);
      digit_acc = '0;
      dec_results++;
    end
    // Any other byte in decode mode is ignored, after any restart.
  endtask

  // Rising edge: take note of every handshake. The output is checked before
  // the input is predicted, as no beat can be caused by a byte taken at the
  // same edge.
  always @(posedge clk) begin
    codec_symbol_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        decode_sel = cfg_data;
        cfg_taken  = 1'b1;
        cfg_writes++;
      end
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        symbols_seen++;
        if (due_symbols.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("[%0t] stray beat: data=%02h last=%0b", $realtime, out_tdata,
                     out_tlast);
        end else begin
          e = due_symbols.pop_front();
          if (out_tdata !== e.data || out_tlast !== e.last) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("[%0t] mismatch: expected data=%02h last=%0b, got data=%02h last=%0b",
                       $realtime, e.data, e.last, out_tdata, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        forecast_symbols(in_tdata, in_tuser);
        in_taken = 1'b1;
        items_taken++;
      end
    end
  end

  // Falling edge: the sender. A beat on offer is held until it is taken;
  // after that the next byte first waits out its own gap.
  always @(negedge clk) begin
    byte_item_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (byte_backlog.size() != 0 && byte_backlog[0].gap != 0) begin
        byte_backlog[0].gap--;
        in_tvalid <= 1'b0;
      end else if (byte_backlog.size() != 0) begin
        cur = byte_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= cur.data;
        in_tuser  <= cur.restart;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Falling edge: the receiver. After each beat it draws a stall, and a long
  // hold-off overrides everything while it runs.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken  = 1'b0;
        stall_left = $urandom_range(0, stall_ceiling);
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long hold-off counter, loaded on request and counted down each cycle.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic rs);
    byte_item_t it;
    it.data    = b;
    it.restart = rs;
    it.gap     = $urandom_range(0, gap_ceiling);
    byte_backlog.push_back(it);
  endtask

  // Sender stops and waits until every owed symbol has come, then lets the
  // block finish anything that causes no result.
  task automatic drain_codec();
    while (byte_backlog.size() != 0 || in_tvalid) @(posedge clk);
    while (due_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    drain_codec();
    @(negedge clk);
    cfg_taken = 1'b0;
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned gap_max, input int unsigned stall_max);
    @(posedge clk);
    gap_ceiling   = gap_max;
    stall_ceiling = stall_max;
  endtask

  // One decimal token, the way an encoder writes it, sometimes with a stray
  // byte in front and now and then broken off before its '#'.
  task automatic push_token();
    int unsigned nd;
    logic        rs;
    rs = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 5) == 0) begin
      push_item($urandom_range(0, 255), rs);
      rs = 1'b0;
    end
    nd = $urandom_range(0, 5);
    for (int k = 0; k < nd; k++) begin
      push_item(ZERO_CHAR + $urandom_range(0, 9), rs);
      rs = 1'b0;
    end
    if ($urandom_range(0, 11) != 0)
      push_item(TERM_CHAR, rs);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed encode: one, two and three digit sums, extreme bytes, a zero
    // byte, and restarts that bring the position back to one.
    write_mode(1'b0);
    push_item(8'd8,   1'b1);
    push_item(8'd8,   1'b0);
    push_item(8'd97,  1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd0,   1'b0);
    push_item(8'h80,  1'b0);
    push_item(8'd0,   1'b1);
    push_item(8'd255, 1'b1);

    // Directed decode: a plain token, a bare '#', an accumulator that wraps,
    // bytes either side of the digit range and of '#', a restart carried by
    // an ignored byte, and a zero token right after it.
    write_mode(1'b1);
    push_item("1", 1'b1);
    push_item(TERM_CHAR, 1'b0);
    push_item(TERM_CHAR, 1'b0);
    for (int k = 0; k < 5; k++) push_item("9", 1'b0);
    push_item(TERM_CHAR, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item("/",   1'b0);
    push_item(":",   1'b0);
    push_item("\"",  1'b0);
    push_item("$",   1'b1);
    push_item("0",   1'b0);
    push_item(TERM_CHAR, 1'b0);

    // Random encode with idling on both sides.
    write_mode(1'b0);
    for (int k = 0; k < 100; k++)
      push_item($urandom_range(0, 255), $urandom_range(0, 15) == 0);

    // Random decode: mostly well-formed tokens with random content.
    write_mode(1'b1);
    for (int k = 0; k < 40; k++) push_token();

    // Encode under pressure: the receiver holds off for a long stretch
    // while the sender keeps offering back-to-back bytes.
    write_mode(1'b0);
    set_idling(0, 3);
    @(negedge clk);
    hold_request = 400;
    for (int k = 0; k < 40; k++)
      push_item($urandom_range(0, 255), $urandom_range(0, 15) == 0);
    // The sender then pauses until everything owed has come back.
    drain_codec();
    set_idling(7, 7);
    for (int k = 0; k < 40; k++)
      push_item($urandom_range(0, 255), $urandom_range(0, 15) == 0);

    // Decode with no idling at all.
    write_mode(1'b1);
    set_idling(0, 0);
    for (int k = 0; k < 20; k++) push_token();

    // Encode once more after decoding: extreme bytes and zero bytes with the
    // position carried on from the earlier encode phase.
    write_mode(1'b0);
    set_idling(7, 7);
    push_item(8'd255, 1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd0,   1'b0);
    push_item(8'h7F,  1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd0,   1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd1,   1'b0);

    drain_codec();
    $display("Covered %0d byte beats (%0d encoded, %0d tokens decoded), %0d result beats,",
             items_taken, enc_items, dec_results, symbols_seen);
    $display("%0d mode writes and a long output stall; %0d faults.",
             cfg_writes, fault_count);
    if (fault_count == 0 && due_symbols.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/podc_pkg.sv
rtl/podc_dabble.sv
rtl/position_offset_decimal_codec_unit.sv
rtl/podc_checker.sv
bench/tb_position_offset_decimal_codec_unit.sv
